@@ rtl/aob_pkg.sv @@
// ----------------------------------------------------------------------------
// aob_pkg: shared definitions of the alpha over blend block
// Channel width, derived datapath widths, pipeline depths and the types that
// travel between the front end, the divider lanes and the merge stage.
// ----------------------------------------------------------------------------
package aob_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int NUM_COLORS   = 3;
  localparam int NUM_LANES    = NUM_COLORS;

  // Product of two channels, the weighted sum, and the doubled rounding terms.
  localparam int PROD_W = 2 * CHANNEL_BITS;
  localparam int PN_W   = 3 * CHANNEL_BITS;
  localparam int NUM_W  = 3 * CHANNEL_BITS + 1;
  localparam int DIV_W  = 2 * CHANNEL_BITS + 1;

  localparam int PREP_STAGES = 4;
  localparam int DIV_STAGES  = CHANNEL_BITS;
  localparam int PIPE_STAGES = PREP_STAGES + DIV_STAGES;

  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef logic [NUM_COLORS-1:0][CHANNEL_BITS-1:0] rgb_t;

  localparam chan_t CH_MAX = '1;
  localparam logic [PROD_W-1:0] CH_MAX_SQ = PROD_W'(CH_MAX) * PROD_W'(CH_MAX);

  // Load enables of every pipeline register bank.
  typedef struct packed {
    logic [PREP_STAGES-1:0] prep_en;
    logic [DIV_STAGES-1:0]  div_en;
    logic                   out_en;
  } stage_ctrl_t;

  // Rounded division request: quotient = num2 / dvsr.
  typedef struct packed {
    logic [NUM_W-1:0] num2;
    logic [DIV_W-1:0] dvsr;
  } div_req_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha;
  } result_t;

endpackage

@@ rtl/aob_if.sv @@
// ----------------------------------------------------------------------------
// aob_if: pixel channels of the alpha over blend block
// The input channel carries a top and bottom RGBA pixel, the output channel
// the composite pixel, each with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface aob_in_if;
  import aob_pkg::*;

  logic  valid;
  logic  ready;
  chan_t top_red;
  chan_t top_green;
  chan_t top_blue;
  chan_t top_alpha;
  chan_t bottom_red;
  chan_t bottom_green;
  chan_t bottom_blue;
  chan_t bottom_alpha;

  modport source (
    output valid, top_red, top_green, top_blue, top_alpha,
           bottom_red, bottom_green, bottom_blue, bottom_alpha,
    input  ready
  );

  modport sink (
    input  valid, top_red, top_green, top_blue, top_alpha,
           bottom_red, bottom_green, bottom_blue, bottom_alpha,
    output ready
  );
endinterface

interface aob_out_if;
  import aob_pkg::*;

  logic  valid;
  logic  ready;
  chan_t out_red;
  chan_t out_green;
  chan_t out_blue;
  chan_t out_alpha;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha,
    input  ready
  );

  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha,
    output ready
  );
endinterface

@@ rtl/aob_prep.sv @@
// ----------------------------------------------------------------------------
// aob_prep: weight and numerator front end
// Forms the coverage D, the colour weights and the doubled, rounding-biased
// numerators and divisors for the three colour lanes, and the rounded alpha.
// ----------------------------------------------------------------------------
module aob_prep (
  input  logic                                        clk,
  input  aob_pkg::stage_ctrl_t                        ctrl,
  input  aob_pkg::rgb_t                               top_rgb,
  input  aob_pkg::rgb_t                               bot_rgb,
  input  aob_pkg::chan_t                              top_a,
  input  aob_pkg::chan_t                              bot_a,
  output aob_pkg::div_req_t [aob_pkg::NUM_LANES-1:0]  lane_req,
  output aob_pkg::chan_t                              alpha,
  output logic                                        zero
);
  import aob_pkg::*;

  // Stage 0: inverse coverage product and the two weights.
  rgb_t              top0_r, bot0_r;
  logic [PROD_W-1:0] pm0_r, wt0_r, wb0_r;
  logic              zero0_r;

  // Stage 1: coverage D and the top products.
  logic [PROD_W-1:0]                 d1_r, wb1_r;
  logic [NUM_COLORS-1:0][PN_W-1:0]   ptop1_r;
  rgb_t                              bot1_r;
  logic                              zero1_r;

  // Stage 2: weighted colour sums.
  logic [PROD_W-1:0]                 d2_r;
  logic [NUM_COLORS-1:0][PN_W-1:0]   n2_r;
  logic                              zero2_r;

  // Stage 3: division requests and the finished alpha.
  div_req_t [NUM_LANES-1:0] req3_r;
  chan_t                    alpha3_r;
  logic                     zero3_r;
  logic [PROD_W-1:0]        alpha_y;
  logic [DIV_W-1:0]         alpha_s;

  always_ff @(posedge clk) begin
    if (ctrl.prep_en[0]) begin
      top0_r  <= top_rgb;
      bot0_r  <= bot_rgb;
      pm0_r   <= PROD_W'(CH_MAX - top_a) * PROD_W'(CH_MAX - bot_a);
      wt0_r   <= {top_a, {CHANNEL_BITS{1'b0}}} - PROD_W'(top_a);
      wb0_r   <= PROD_W'(bot_a) * PROD_W'(CH_MAX - top_a);
      zero0_r <= (top_a == '0) && (bot_a == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.prep_en[1]) begin
      d1_r    <= CH_MAX_SQ - pm0_r;
      wb1_r   <= wb0_r;
      bot1_r  <= bot0_r;
      zero1_r <= zero0_r;
      for (int c = 0; c < NUM_COLORS; c++) begin
        ptop1_r[c] <= PN_W'(top0_r[c]) * PN_W'(wt0_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.prep_en[2]) begin
      d2_r    <= d1_r;
      zero2_r <= zero1_r;
      for (int c = 0; c < NUM_COLORS; c++) begin
        n2_r[c] <= ptop1_r[c] + PN_W'(bot1_r[c]) * PN_W'(wb1_r);
      end
    end
  end

  // Alpha is round(D/M) = floor((D + (M-1)/2) / M). With M = 2^B - 1 the
  // division of y by M is (y + (y >> B) + 1) >> B, exact over this range.
  assign alpha_y = d2_r + PROD_W'(CH_MAX >> 1);
  assign alpha_s = DIV_W'(alpha_y) + DIV_W'(alpha_y >> CHANNEL_BITS) + DIV_W'(1'b1);

  // round(n/d) = (2n + d) / (2d) for every colour lane.
  always_ff @(posedge clk) begin
    if (ctrl.prep_en[3]) begin
      zero3_r  <= zero2_r;
      alpha3_r <= alpha_s[PROD_W-1:CHANNEL_BITS];
      for (int c = 0; c < NUM_COLORS; c++) begin
        req3_r[c].num2 <= {n2_r[c], 1'b0} + NUM_W'(d2_r);
        req3_r[c].dvsr <= {d2_r, 1'b0};
      end
    end
  end

  assign lane_req = req3_r;
  assign alpha    = alpha3_r;
  assign zero     = zero3_r;

endmodule

@@ rtl/aob_div_lane.sv @@
// ----------------------------------------------------------------------------
// aob_div_lane: pipelined restoring divider lane
// Resolves one quotient bit per stage, most significant first. The quotient
// is known to fit in one channel, so the divisor starts aligned to its top bit.
// ----------------------------------------------------------------------------
module aob_div_lane (
  input  logic                  clk,
  input  aob_pkg::stage_ctrl_t  ctrl,
  input  aob_pkg::div_req_t     req,
  output aob_pkg::chan_t        quo
);
  import aob_pkg::*;

  logic [NUM_W-1:0] rem_r [DIV_STAGES-1];
  logic [DIV_W-1:0] dv_r  [DIV_STAGES-1];
  chan_t            q_r   [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    localparam int BIT = DIV_STAGES - 1 - k;

    logic [NUM_W-1:0] rem_in;
    logic [DIV_W-1:0] dv_in;
    chan_t            q_in;
    logic [NUM_W-1:0] trial;
    logic             fits;

    if (k == 0) begin : g_first
      assign rem_in = req.num2;
      assign dv_in  = req.dvsr;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign dv_in  = dv_r[k-1];
      assign q_in   = q_r[k-1];
    end

    assign trial = NUM_W'(dv_in) << BIT;
    assign fits  = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (ctrl.div_en[k]) begin
        q_r[k] <= fits ? (q_in | (chan_t'(1) << BIT)) : q_in;
      end
    end

    if (k < DIV_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (ctrl.div_en[k]) begin
          rem_r[k] <= fits ? (rem_in - trial) : rem_in;
          dv_r[k]  <= dv_in;
        end
      end
    end
  end

  assign quo = q_r[DIV_STAGES-1];

endmodule

@@ rtl/aob_merge.sv @@
// ----------------------------------------------------------------------------
// aob_merge: lane merge and output register
// Gathers the three colour quotients and the alpha into one composite pixel,
// forces the fully transparent case to zero, and holds the result until taken.
// ----------------------------------------------------------------------------
module aob_merge (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  aob_pkg::stage_ctrl_t                    ctrl,
  input  logic                                    stage_valid,
  input  logic                                    zero,
  input  aob_pkg::chan_t [aob_pkg::NUM_LANES-1:0] lane_q,
  input  aob_pkg::chan_t                          alpha,
  output logic                                    res_valid,
  output aob_pkg::result_t                        res
);
  import aob_pkg::*;

  logic    res_valid_r;
  result_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (ctrl.out_en) begin
      res_valid_r <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_en) begin
      if (zero) begin
        res_r <= '0;
      end else begin
        res_r.red   <= lane_q[0];
        res_r.green <= lane_q[1];
        res_r.blue  <= lane_q[2];
        res_r.alpha <= alpha;
      end
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

@@ rtl/alpha_over_blend.sv @@
// ----------------------------------------------------------------------------
// alpha_over_blend: Porter-Duff over compositing, straight alpha
// Composites a top RGBA pixel over a bottom RGBA pixel in unsigned
// normalized channels, rounding every output to nearest.
// ----------------------------------------------------------------------------
// Usage:
//   A request on in_pix carries one top and one bottom pixel. It is taken at
//   a rising edge of clk at which in_pix.valid and in_pix.ready are both
//   high. The composite pixel leaves on out_pix under the same handshake.
// Throughput and stages:
//   One request per cycle, sustained while out_pix.ready stays high. A request
//   passes through the PREP_STAGES front-end stages and the DIV_STAGES divider
//   stages before it reaches the output register. The divider lanes resolve
//   one quotient bit per pipeline stage.
// Stalls:
//   Every stage has its own valid bit. When out_pix.ready is low the output
//   register holds its result and the stages behind it keep filling any
//   empty slots; in_pix.ready drops only once every stage is occupied.
// Reset:
//   rst_n is synchronous and active low. It clears all valid bits, so no
//   result is presented after reset; the datapath registers are not reset.
// ----------------------------------------------------------------------------
module alpha_over_blend (
  input  logic       clk,
  input  logic       rst_n,
  aob_in_if.sink     in_pix,
  aob_out_if.source  out_pix
);
  import aob_pkg::*;

  localparam logic [PIPE_STAGES-1:0] ALL_VALID = '1;

  // Valid bit of every pipeline stage, front end first, then the divider.
  logic [PIPE_STAGES-1:0] v_r, v_nxt, v_shift;
  logic [PIPE_STAGES-1:0] stage_rdy;
  logic                   out_free;

  // Transparent-pair flag and finished alpha, carried alongside the divider.
  logic [DIV_STAGES-1:0]  zd_r, zd_shift;
  chan_t [DIV_STAGES-1:0] ad_r, ad_shift;

  stage_ctrl_t                    ctrl;
  rgb_t                           top_rgb, bot_rgb;
  div_req_t [NUM_LANES-1:0]       lane_req;
  chan_t [NUM_LANES-1:0]          lane_q;
  chan_t                          prep_alpha;
  logic                           prep_zero;
  logic                           res_valid;
  result_t                        res;

  // A stage may load when the output register can take a result, or when
  // it or any stage between it and the output is empty.
  assign out_free = !res_valid || out_pix.ready;

  always_comb begin
    for (int k = 0; k < PIPE_STAGES; k++) begin
      stage_rdy[k] = out_free || ((v_r >> k) != (ALL_VALID >> k));
    end
  end

  assign ctrl.prep_en = stage_rdy[PREP_STAGES-1:0];
  assign ctrl.div_en  = stage_rdy[PIPE_STAGES-1:PREP_STAGES];
  assign ctrl.out_en  = out_free;

  assign in_pix.ready = stage_rdy[0];

  assign v_shift = {v_r[PIPE_STAGES-2:0], in_pix.valid};

  always_comb begin
    v_nxt = v_r;
    for (int k = 0; k < PIPE_STAGES; k++) begin
      if (stage_rdy[k]) begin
        v_nxt[k] = v_shift[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign zd_shift = {zd_r[DIV_STAGES-2:0], prep_zero};
  assign ad_shift = {ad_r[DIV_STAGES-2:0], prep_alpha};

  always_ff @(posedge clk) begin
    for (int j = 0; j < DIV_STAGES; j++) begin
      if (ctrl.div_en[j]) begin
        zd_r[j] <= zd_shift[j];
        ad_r[j] <= ad_shift[j];
      end
    end
  end

  assign top_rgb = {in_pix.top_blue, in_pix.top_green, in_pix.top_red};
  assign bot_rgb = {in_pix.bottom_blue, in_pix.bottom_green, in_pix.bottom_red};

  aob_prep u_prep (
    .clk      (clk),
    .ctrl     (ctrl),
    .top_rgb  (top_rgb),
    .bot_rgb  (bot_rgb),
    .top_a    (in_pix.top_alpha),
    .bot_a    (in_pix.bottom_alpha),
    .lane_req (lane_req),
    .alpha    (prep_alpha),
    .zero     (prep_zero)
  );

  // Three colour lanes, all the same divider. The alpha only needs a division
  // by full scale, which the front end finishes on its own.
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    aob_div_lane u_lane (
      .clk  (clk),
      .ctrl (ctrl),
      .req  (lane_req[l]),
      .quo  (lane_q[l])
    );
  end

  aob_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .stage_valid (v_r[PIPE_STAGES-1]),
    .zero        (zd_r[DIV_STAGES-1]),
    .lane_q      (lane_q),
    .alpha       (ad_r[DIV_STAGES-1]),
    .res_valid   (res_valid),
    .res         (res)
  );

  assign out_pix.valid     = res_valid;
  assign out_pix.out_red   = res.red;
  assign out_pix.out_green = res.green;
  assign out_pix.out_blue  = res.blue;
  assign out_pix.out_alpha = res.alpha;

endmodule

@@ rtl/aob_checker.sv @@
// ----------------------------------------------------------------------------
// aob_checker: port-level checks of the alpha over blend block
// Watches the result channel for handshake rules, reset behavior and a
// property of the compositing math.
// ----------------------------------------------------------------------------
module aob_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_ready,
  input aob_pkg::chan_t out_red,
  input aob_pkg::chan_t out_green,
  input aob_pkg::chan_t out_blue,
  input aob_pkg::chan_t out_alpha
);
  import aob_pkg::*;

  // A pending result is never withdrawn.
  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable({out_red, out_green, out_blue, out_alpha}))
    else $error("result payload changed while stalled");

  // Reset leaves no result on the channel.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result presented right after reset");

  // Any nonzero coverage rounds to at least one code, so zero alpha
  // only comes from the transparent pair, whose colour is all zero.
  a_clear_is_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_alpha == '0) |->
      (out_red == '0) && (out_green == '0) && (out_blue == '0))
    else $error("zero alpha with nonzero colour");

endmodule

bind alpha_over_blend aob_checker u_aob_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_pix.valid),
  .out_ready (out_pix.ready),
  .out_red   (out_pix.out_red),
  .out_green (out_pix.out_green),
  .out_blue  (out_pix.out_blue),
  .out_alpha (out_pix.out_alpha)
);

@@ sim/alpha_over_blend_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_over_blend_tb: self-checking bench for the alpha over blend block
// Pixel pairs are sent through the input channel under several idling
// patterns. Each composite is predicted in exact integer arithmetic and
// compared field by field as it leaves the output channel.
// ----------------------------------------------------------------------------
module alpha_over_blend_tb;
  import aob_pkg::*;

  // Cycles without any accepted request before the run is declared hung.
  // Stall runs are geometric at 62 percent at worst, so real runs stay short.
  localparam int HANG_LIMIT  = 5000;
  localparam int MAX_REPORTS = 40;

  // One request on the input channel: the upper and the lower RGBA pixel.
  typedef struct packed {
    chan_t top_red;
    chan_t top_green;
    chan_t top_blue;
    chan_t top_alpha;
    chan_t bottom_red;
    chan_t bottom_green;
    chan_t bottom_blue;
    chan_t bottom_alpha;
  } pixel_pair_t;

  logic clk = 1'b0;
  logic rst_n;

  aob_in_if  in_ch ();
  aob_out_if out_ch ();

  alpha_over_blend i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_ch),
    .out_pix (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Composites still owed by the block, oldest first.
  result_t pending_composites[$];

  // Percent of cycles in which the sender holds back or the receiver stalls.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  int fail_count        = 0;
  int pairs_sent        = 0;
  int composites_seen   = 0;
  int transparent_pairs = 0;
  int idle_cycles       = 0;
  bit run_done          = 1'b0;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Divide and round to nearest, a tie going upward.
  function automatic longint unsigned round_div(longint unsigned num, longint unsigned den);
    return (2 * num + den) / (2 * den);
  endfunction

  // Straight-alpha "over": the top pixel weighted by its own alpha, the bottom
  // one by its alpha times what the top lets through, normalized by the
  // combined coverage. Two fully transparent pixels give an all-zero result.
  function automatic result_t blend_over(pixel_pair_t pair);
    longint unsigned full, ta, ba, cov, w_top, w_bot;
    result_t res;
    full  = CH_MAX;
    ta    = pair.top_alpha;
    ba    = pair.bottom_alpha;
    cov   = full * full - (full - ta) * (full - ba);
    if (cov == 0) begin
      return '0;
    end
    w_top = ta * full;
    w_bot = ba * (full - ta);
    res.red   = chan_t'(round_div(longint'(pair.top_red) * w_top
                                  + longint'(pair.bottom_red) * w_bot, cov));
    res.green = chan_t'(round_div(longint'(pair.top_green) * w_top
                                  + longint'(pair.bottom_green) * w_bot, cov));
    res.blue  = chan_t'(round_div(longint'(pair.top_blue) * w_top
                                  + longint'(pair.bottom_blue) * w_bot, cov));
    res.alpha = chan_t'(round_div(cov, full));
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Sends one pixel pair, with random hold-off first when the phase asks for
  // it. The task returns in the time step of the edge that took the request,
  // so a following call can keep valid high without a gap.
  task automatic send_pair(input pixel_pair_t pair);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.top_red      <= pair.top_red;
    in_ch.top_green    <= pair.top_green;
    in_ch.top_blue     <= pair.top_blue;
    in_ch.top_alpha    <= pair.top_alpha;
    in_ch.bottom_red   <= pair.bottom_red;
    in_ch.bottom_green <= pair.bottom_green;
    in_ch.bottom_blue  <= pair.bottom_blue;
    in_ch.bottom_alpha <= pair.bottom_alpha;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) begin
      @(posedge clk);
    end
    pending_composites.push_back(blend_over(pair));
    pairs_sent++;
    if (pair.top_alpha == 0 && pair.bottom_alpha == 0) begin
      transparent_pairs++;
    end
  endtask

  // Drops valid and waits until every composite owed has been checked.
  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    while (pending_composites.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Alphas lean toward the corners, where the weighting changes character:
  // fully transparent, fully opaque and just off either end.
  function automatic chan_t rand_alpha();
    case ($urandom_range(9))
      0, 1:    return '0;
      2:       return CH_MAX;
      3:       return chan_t'($urandom_range(3, 1));
      4:       return CH_MAX - chan_t'($urandom_range(3, 1));
      default: return chan_t'($urandom_range(255));
    endcase
  endfunction

  function automatic pixel_pair_t rand_pair();
    pixel_pair_t pair;
    pair.top_red      = chan_t'($urandom_range(255));
    pair.top_green    = chan_t'($urandom_range(255));
    pair.top_blue     = chan_t'($urandom_range(255));
    pair.top_alpha    = rand_alpha();
    pair.bottom_red   = chan_t'($urandom_range(255));
    pair.bottom_green = chan_t'($urandom_range(255));
    pair.bottom_blue  = chan_t'($urandom_range(255));
    pair.bottom_alpha = rand_alpha();
    return pair;
  endfunction

  task automatic send_random_pairs(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      send_pair(rand_pair());
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: checks each accepted composite, then picks the next ready.
  // --------------------------------------------------------------------------

  task automatic compare_channel(input string field, input chan_t want, input chan_t got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    end
  endtask

  task automatic check_composite();
    result_t want;
    if (pending_composites.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("%0t ns: composite with nothing pending, expected none, actual %0d %0d %0d %0d",
                 $time, out_ch.out_red, out_ch.out_green, out_ch.out_blue, out_ch.out_alpha);
      end
      return;
    end
    want = pending_composites.pop_front();
    compare_channel("red",   want.red,   out_ch.out_red);
    compare_channel("green", want.green, out_ch.out_green);
    compare_channel("blue",  want.blue,  out_ch.out_blue);
    compare_channel("alpha", want.alpha, out_ch.out_alpha);
    composites_seen++;
  endtask

  // Values read here are the ones that stood before the edge, since the block
  // and this bench both update through nonblocking assignments.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && $isunknown(out_ch.valid)) begin
      fail_count++;
      $display("%0t ns: out valid unknown, expected 0 or 1, actual %b", $time, out_ch.valid);
    end else if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      check_composite();
    end
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Hang detection: any accepted request on either side restarts the count.
  always @(posedge clk) begin
    if (!run_done) begin
      if ((in_ch.valid & in_ch.ready) === 1'b1 || (out_ch.valid & out_ch.ready) === 1'b1) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= HANG_LIMIT) begin
        $display("%0t ns: no request accepted for %0d cycles, %0d composites pending",
                 $time, HANG_LIMIT, pending_composites.size());
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Corners of the blend, sent back to back: two transparent pixels (with and
  // without colour behind them), an opaque top that must pass through
  // unchanged, a transparent top that must show the bottom, the smallest
  // nonzero coverage, full-scale and alternating bit patterns.
  task automatic test_corner_pixels();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_pair(pixel_pair_t'{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0});
    send_pair(pixel_pair_t'{8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 8'd0});
    send_pair(pixel_pair_t'{8'd12,  8'd200, 8'd255, 8'd255, 8'd90,  8'd33,  8'd7,   8'd128});
    send_pair(pixel_pair_t'{8'd200, 8'd100, 8'd50,  8'd0,   8'd17,  8'd34,  8'd51,  8'd255});
    send_pair(pixel_pair_t'{8'd1,   8'd128, 8'd254, 8'd255, 8'd250, 8'd3,   8'd77,  8'd255});
    send_pair(pixel_pair_t'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255});
    send_pair(pixel_pair_t'{8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 8'd0,   8'd128, 8'd1});
    send_pair(pixel_pair_t'{8'd255, 8'd0,   8'd128, 8'd1,   8'd9,   8'd255, 8'd0,   8'd0});
    send_pair(pixel_pair_t'{8'd255, 8'd0,   8'd255, 8'd1,   8'd0,   8'd255, 8'd0,   8'd1});
    send_pair(pixel_pair_t'{8'd0,   8'd255, 8'd0,   8'd128, 8'd255, 8'd0,   8'd255, 8'd128});
    send_pair(pixel_pair_t'{8'hAA,  8'hAA,  8'hAA,  8'hAA,  8'h55,  8'h55,  8'h55,  8'h55});
    send_pair(pixel_pair_t'{8'h55,  8'h55,  8'h55,  8'h55,  8'hAA,  8'hAA,  8'hAA,  8'hAA});
    send_pair(pixel_pair_t'{8'd254, 8'd1,   8'd127, 8'd254, 8'd1,   8'd254, 8'd128, 8'd254});
    send_pair(pixel_pair_t'{8'd255, 8'd255, 8'd255, 8'd127, 8'd0,   8'd0,   8'd0,   8'd255});
    send_pair(pixel_pair_t'{8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 8'd255, 8'd0});
    send_pair(pixel_pair_t'{8'd77,  8'd154, 8'd231, 8'd0,   8'd33,  8'd66,  8'd99,  8'd128});
  endtask

  // Full rate in both directions keeps every pipeline stage busy.
  task automatic test_back_to_back();
    send_random_pairs(180, 0, 0);
  endtask

  // A sparse sender leaves holes between requests in the pipeline.
  task automatic test_sender_gaps();
    send_random_pairs(170, 62, 0);
  endtask

  // A slow receiver fills every stage until the block must push back.
  task automatic test_receiver_stalls();
    send_random_pairs(170, 0, 62);
  endtask

  // Light idling on both sides mixes short bubbles with short stalls.
  task automatic test_mixed_idling();
    send_random_pairs(170, 9, 9);
  endtask

  // Bursts against a stalling receiver, each followed by a full drain, so
  // the block is seen going from empty to full and back again.
  task automatic test_drain_between_bursts();
    repeat (3) begin
      send_random_pairs(50, 0, 62);
      hold_until_drained();
    end
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.top_red      <= '0;
    in_ch.top_green    <= '0;
    in_ch.top_blue     <= '0;
    in_ch.top_alpha    <= '0;
    in_ch.bottom_red   <= '0;
    in_ch.bottom_green <= '0;
    in_ch.bottom_blue  <= '0;
    in_ch.bottom_alpha <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_corner_pixels();
    test_back_to_back();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idling();
    test_drain_between_bursts();

    // Let the last composites out, then keep the clock running to catch
    // anything the block might still emit without being asked.
    hold_until_drained();
    repeat (PIPE_STAGES + 8) @(posedge clk);
    run_done = 1'b1;

    $display("Blended %0d pixel pairs in six tests under four idling mixes, %0d fully transparent.",
             pairs_sent, transparent_pairs);
    $display("Checked %0d composites field by field; %0d field errors.",
             composites_seen, fail_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
